[sv/mss_pkg.sv]
package mss_pkg;

   // fixed field widths
   localparam int SAMPLE_W     = 32;
   localparam int SUM_W        = 47;
   localparam int IDX_W        = 16;
   localparam int LEN_W        = 17;

   // build choices
   localparam int MAX_ELEMENTS = 65536;
   localparam int SAMPLE_BITS  = 32;

   // derived
   localparam int ACC_W        = SUM_W + 2;   // run sum plus a signed sample, no wrap
   localparam int SEEN_W       = $clog2(MAX_ELEMENTS + 1);
   localparam int OUT_DATA_W   = ((SUM_W + IDX_W + LEN_W + 7) / 8) * 8;
   localparam int OUT_PAD_W    = OUT_DATA_W - (SUM_W + IDX_W + LEN_W);

   localparam logic [SUM_W-1:0] SUM_TOP = {SUM_W{1'b1}};
   localparam logic [LEN_W-1:0] LEN_TOP = {LEN_W{1'b1}};

   typedef struct packed {
      logic [LEN_W-1:0] best_length;
      logic [IDX_W-1:0] best_begin;
      logic [SUM_W-1:0] best_total;
   } result_type;

endpackage

[sv/mss_core.sv]
// Kadane update: running sum and length, best-run tracking, per-sequence clear.
module mss_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          take,
   input  logic [mss_pkg::SAMPLE_W-1:0]  sample,
   input  logic                          last,
   output logic                          done,
   output mss_pkg::result_type           result
);
   import mss_pkg::*;

   logic [SUM_W-1:0]  run_sum_ff,    run_sum_in;
   logic [LEN_W-1:0]  run_length_ff, run_length_in;
   logic [SUM_W-1:0]  top_sum_ff,    top_sum_in;
   logic [LEN_W-1:0]  top_length_ff, top_length_in;
   logic [IDX_W-1:0]  top_start_ff,  top_start_in;
   logic [IDX_W-1:0]  position_ff,   position_in;
   logic [SEEN_W-1:0] seen_ff,       seen_in;

   logic signed [SAMPLE_BITS-1:0] smp_low;
   logic signed [ACC_W-1:0]       smp_ext;
   logic signed [ACC_W-1:0]       run_ext;
   logic signed [ACC_W-1:0]       acc_sum;
   logic                          acc_pos;
   logic                          acc_sat;
   logic [SUM_W-1:0]              new_sum;
   logic [LEN_W-1:0]              new_len;
   logic                          live;
   logic                          better;

   always_comb begin
      smp_low = $signed(sample[SAMPLE_BITS-1:0]);
      smp_ext = ACC_W'(smp_low);
      run_ext = $signed({2'b00, run_sum_ff});
      acc_sum = run_ext + smp_ext;
      acc_pos = !acc_sum[ACC_W-1] && (acc_sum != '0);
      acc_sat = !acc_sum[ACC_W-1] && acc_sum[SUM_W];
      new_sum = acc_sat ? SUM_TOP : acc_sum[SUM_W-1:0];
      new_len = (run_length_ff == LEN_TOP) ? LEN_TOP : run_length_ff + LEN_W'(1);
      live    = seen_ff < SEEN_W'(MAX_ELEMENTS);
      better  = (new_sum > top_sum_ff) ||
                ((new_sum == top_sum_ff) && (new_len < top_length_ff));

      run_sum_in    = run_sum_ff;
      run_length_in = run_length_ff;
      top_sum_in    = top_sum_ff;
      top_length_in = top_length_ff;
      top_start_in  = top_start_ff;
      position_in   = position_ff;
      seen_in       = seen_ff;

      if (take && live) begin
         if (acc_pos) begin
            run_sum_in    = new_sum;
            run_length_in = new_len;
            if (better) begin
               top_sum_in    = new_sum;
               top_length_in = new_len;
               top_start_in  = IDX_W'(position_ff + IDX_W'(1) - new_len[IDX_W-1:0]);
            end
         end else begin
            run_sum_in    = '0;
            run_length_in = '0;
         end
         position_in = position_ff + IDX_W'(1);
         seen_in     = seen_ff + SEEN_W'(1);
      end

      // the result carries this word's update
      done               = take && last;
      result.best_total  = top_sum_in;
      result.best_begin  = top_start_in;
      result.best_length = top_length_in;

      if (done) begin
         run_sum_in    = '0;
         run_length_in = '0;
         top_sum_in    = '0;
         top_length_in = '0;
         top_start_in  = '0;
         position_in   = '0;
         seen_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_sum_ff    <= '0;
         run_length_ff <= '0;
         top_sum_ff    <= '0;
         top_length_ff <= '0;
         top_start_ff  <= '0;
         position_ff   <= '0;
         seen_ff       <= '0;
      end else begin
         run_sum_ff    <= run_sum_in;
         run_length_ff <= run_length_in;
         top_sum_ff    <= top_sum_in;
         top_length_ff <= top_length_in;
         top_start_ff  <= top_start_in;
         position_ff   <= position_in;
         seen_ff       <= seen_in;
      end
   end

   // an open run always has a positive sum, an empty one none
   assert property (@(posedge clock) disable iff (reset)
      (run_sum_ff == '0) == (run_length_ff == '0))
      else $error("run sum and run length disagree");

   // a recorded best run is never empty
   assert property (@(posedge clock) disable iff (reset)
      (top_sum_ff == '0) == (top_length_ff == '0))
      else $error("best sum and best length disagree");

   // a closing word leaves the tracker clear
   assert property (@(posedge clock) disable iff (reset)
      done |=> (seen_ff == '0) && (top_sum_ff == '0) && (position_ff == '0))
      else $error("state not cleared after last word");

endmodule

[sv/mss_out_skid.sv]
// Result register with one skid slot behind it.
module mss_out_skid (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  mss_pkg::result_type  push_data,
   output logic                 space,
   output logic                 out_valid,
   input  logic                 out_ready,
   output mss_pkg::result_type  out_data
);
   import mss_pkg::*;

   logic       out_valid_ff,  out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_data_ff,   out_data_in;
   result_type skid_data_ff,  skid_data_in;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign space     = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   // the skid slot fills only behind a waiting result
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a word while output is empty");

   // nothing is pushed while the skid slot is taken
   assert property (@(posedge clock) disable iff (reset)
      push |-> !skid_valid_ff)
      else $error("push into a full buffer");

endmodule

[sv/max_subarray_sum_tracker.sv]
// Maximum-sum contiguous run over a sequence of signed samples. Each req word carries
// one sample; the word with tlast high closes the sequence, and one rsp word then gives
// the best run's saturated sum, start index and length (all zero if no sample run was
// positive), after which the tracker is clear for the next sequence. Each word is
// absorbed in the cycle it is accepted, so one word per clock is taken while req_tready
// is high. The result sits in an output register with one skid slot behind it;
// req_tready drops only while both hold a result, and no other stall exists. A result
// appears on rsp in the cycle after the closing req word, unless an earlier result is
// still waiting there, in which case it follows once that one is taken. Samples beyond
// the first MAX_ELEMENTS of a sequence are ignored, though their tlast still closes it.
module max_subarray_sum_tracker (
   input  logic                            clock,
   input  logic                            reset,
   // req: sample in, tdata[31:0] = sample (signed)
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [mss_pkg::SAMPLE_W-1:0]    req_tdata,
   input  logic                            req_tlast,
   // rsp: tdata[46:0] = best_total, [62:47] = best_begin, [79:63] = best_length
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [mss_pkg::OUT_DATA_W-1:0]  rsp_tdata
);
   import mss_pkg::*;

   logic       req_take;   // req word accepted this cycle
   logic       core_done;  // closing word: result ready
   logic       buf_space;
   result_type core_result;
   result_type rsp_result;

   assign req_tready = buf_space;
   assign req_take   = req_tvalid && buf_space;

   mss_core u_core (
      .clock  (clock),
      .reset  (reset),
      .take   (req_take),
      .sample (req_tdata),
      .last   (req_tlast),
      .done   (core_done),
      .result (core_result)
   );

   mss_out_skid u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (core_done),
      .push_data (core_result),
      .space     (buf_space),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_result)
   );

   // pack lowest field first; the layout fills whole bytes exactly
   generate
      if (OUT_PAD_W > 0) begin : g_pad
         assign rsp_tdata = {{OUT_PAD_W{1'b0}}, rsp_result.best_length,
                             rsp_result.best_begin, rsp_result.best_total};
      end else begin : g_nopad
         assign rsp_tdata = {rsp_result.best_length, rsp_result.best_begin,
                             rsp_result.best_total};
      end
   endgenerate

endmodule

[verif/max_subarray_sum_tracker_test.sv]
`timescale 1ns / 1ps

module max_subarray_sum_tracker_test;
   import mss_pkg::*;

   // Scoreboard: tracks the best run of the current sequence from the req words
   // accepted so far, and queues one expected rsp word per closing (tlast) word.
   class best_run_scoreboard;
      logic [SUM_W-1:0]  run_sum, top_sum;
      logic [LEN_W-1:0]  run_len, top_len;
      logic [IDX_W-1:0]  top_start, position;
      int unsigned       taken;
      result_type        expected_best[$];
      int                mismatches;

      function new();
         mismatches = 0;
         clear_run();
      endfunction

      function void clear_run();
         run_sum   = '0;
         run_len   = '0;
         top_sum   = '0;
         top_len   = '0;
         top_start = '0;
         position  = '0;
         taken     = 0;
      endfunction

      function int pending();
         return expected_best.size();
      endfunction

      // one Kadane step on a sign-extended sample
      function void absorb_sample(logic [SAMPLE_W-1:0] raw);
         logic signed [SAMPLE_W-1:0] narrowed;
         logic signed [ACC_W-1:0]    widened, total;
         narrowed = raw << (SAMPLE_W - SAMPLE_BITS);
         narrowed = narrowed >>> (SAMPLE_W - SAMPLE_BITS);
         widened  = narrowed;
         total    = $signed({2'b00, run_sum}) + widened;
         if (total > $signed({2'b00, SUM_TOP}))
            total = $signed({2'b00, SUM_TOP});
         if (total <= 0) begin
            run_sum = '0;
            run_len = '0;
         end else begin
            run_sum = total[SUM_W-1:0];
            if (run_len != LEN_TOP)
               run_len = run_len + LEN_W'(1);
            // larger sum wins; equal sum only if strictly shorter
            if (run_sum > top_sum || (run_sum == top_sum && run_len < top_len)) begin
               top_sum   = run_sum;
               top_len   = run_len;
               top_start = position + IDX_W'(1) - run_len[IDX_W-1:0];
            end
         end
         position = position + IDX_W'(1);
         taken++;
      endfunction

      function void note_word(logic [SAMPLE_W-1:0] raw, logic closing);
         result_type best;
         if (taken < MAX_ELEMENTS)
            absorb_sample(raw);
         if (closing) begin
            best.best_total  = top_sum;
            best.best_begin  = top_start;
            best.best_length = top_len;
            expected_best.push_back(best);
            clear_run();
         end
      endfunction

      function void check_result(logic [OUT_DATA_W-1:0] data);
         result_type got, want;
         got = data[$bits(result_type)-1:0];
         if (expected_best.size() == 0) begin
            if (mismatches < 10)
               $display("%0t: rsp word with nothing expected: total %0d begin %0d len %0d",
                        $realtime, got.best_total, got.best_begin, got.best_length);
            mismatches++;
            return;
         end
         want = expected_best.pop_front();
         if (got.best_total != want.best_total || got.best_begin != want.best_begin ||
             got.best_length != want.best_length) begin
            if (mismatches < 10)
               $display("%0t: mismatch exp total %0d begin %0d len %0d, got %0d %0d %0d",
                        $realtime, want.best_total, want.best_begin, want.best_length,
                        got.best_total, got.best_begin, got.best_length);
            mismatches++;
         end
      endfunction
   endclass

   logic                    clock;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [SAMPLE_W-1:0]     req_tdata  = '0;
   logic                    req_tlast  = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [OUT_DATA_W-1:0]   rsp_tdata;

   best_run_scoreboard      sb;
   bit                      idle_on = 1'b1;   // random gaps and stalls allowed
   int                      stall_left = 0;
   int                      words_sent;

   max_subarray_sum_tracker DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [31:0] sample
      .req_tlast  (req_tlast),    // closes the sequence
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)     // [46:0] total, [62:47] begin, [79:63] length
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run (~520 words, worst gaps and stalls).
   initial begin
      #2_000_000;
      $display("** max_subarray_sum_tracker: FAILED **");
      $finish;
   end

   // Result side: check on the edge where the word is taken, then pick the
   // next tready. Stalls come in random bursts while gaps are allowed.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata);
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Present one req word and hold it until the handshake. Called in the step
   // of a rising edge; returns in the step of the accepting edge with tvalid
   // still high, so back-to-back words need no extra assignment.
   task automatic send_word(input logic [SAMPLE_W-1:0] value, input logic closing);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= closing;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_word(value, closing);
      words_sent++;
   endtask

   // Mostly small values so that ties and restarts are frequent; the rest are
   // the extremes and full-width random words.
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      int small_val;
      case ($urandom_range(0, 9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2, 3:    return $urandom;
         default: begin
            small_val = int'($urandom_range(0, 40)) - 20;
            return SAMPLE_W'(small_val);
         end
      endcase
   endfunction

   task automatic drain_results();
      int guard;
      guard = 0;
      while (sb.pending() != 0 && guard < 2000) begin
         @(posedge clock);
         guard++;
      end
   endtask

   initial begin
      int seq_len;
      sb = new();
      words_sent = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed ---
      // lone extremes
      send_word(32'h7FFF_FFFF, 1'b1);
      send_word(32'h8000_0000, 1'b1);
      send_word(32'h0000_0000, 1'b1);
      // nothing positive: all-zero result
      send_word(-32'sd1, 1'b0);
      send_word(-32'sd5, 1'b0);
      send_word(-32'sd3, 1'b1);
      // equal sum, shorter run later: replaces the best
      send_word(32'sd1, 1'b0);
      send_word(32'sd2, 1'b0);
      send_word(-32'sd3, 1'b0);
      send_word(32'sd3, 1'b1);
      // equal sum, equal length: earlier run stays
      send_word(32'sd5, 1'b0);
      send_word(-32'sd5, 1'b0);
      send_word(32'sd5, 1'b1);
      // run straddling a dip, then extremes
      send_word(32'sd4, 1'b0);
      send_word(-32'sd1, 1'b0);
      send_word(32'sd4, 1'b0);
      send_word(32'h7FFF_FFFF, 1'b0);
      send_word(32'h7FFF_FFFF, 1'b0);
      send_word(32'h8000_0000, 1'b1);

      // --- random sequences ---
      while (words_sent < 500) begin
         seq_len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 16);
         for (int i = 0; i < seq_len; i++)
            send_word(pick_sample(), i == seq_len - 1);
         // after any sequence ending at 250 to 269 words, hold off until the tracker has handed back everything
         if (words_sent >= 250 && words_sent < 270) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (sb.pending() != 0) @(posedge clock);
         end
         // last stretch runs flat out on both sides
         if (words_sent >= 400)
            idle_on = 1'b0;
      end
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;

      drain_results();
      repeat (8) @(posedge clock);
      if (sb.pending() != 0)
         $display("%0d expected results never arrived", sb.pending());
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("** max_subarray_sum_tracker: PASSED **");
      end else begin
         $display("** max_subarray_sum_tracker: FAILED **");
      end
      $finish;
   end

endmodule
